// ===== rtl/core/pidc_pkg.sv =====
// Shared types and constants of the clamped PID controller.
// Used by pidc_cfg, pidc_ctrl, pidc_dpath and pid_controller_clamped.
package pidc_pkg;

  localparam int DataW  = 32;               // Q16.16 data words
  localparam int BoundW = 31;               // windup bound width
  localparam int EnW    = 2;                // term enable bits
  localparam int IdxW   = 3;                // register index width
  localparam int FracW  = 16;               // fraction bits of Q16.16
  localparam int OpW    = DataW + 1;        // multiplier operand width
  localparam int ProdW  = 2 * DataW;        // kept product width
  localparam int AccW   = ProdW + 2;        // sum of three products
  localparam int DrvW   = AccW - FracW;     // drive before clamping
  localparam int IntW   = ProdW - FracW + 2; // integral update width
  localparam int DivW   = DataW + FracW;    // dividend magnitude bits
  localparam int CntW   = $clog2(DivW);

  localparam int EnInteg = 0;
  localparam int EnDeriv = 1;

  typedef enum logic [IdxW-1:0] {
    REG_PROP_GAIN     = 3'd0,
    REG_INTEG_GAIN    = 3'd1,
    REG_DERIV_GAIN    = 3'd2,
    REG_DRIVE_FLOOR   = 3'd3,
    REG_DRIVE_CEILING = 3'd4,
    REG_WINDUP_BOUND  = 3'd5,
    REG_SAMPLE_PERIOD = 3'd6,
    REG_TERM_ENABLES  = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    MUL_PROP   = 2'd0,
    MUL_PERIOD = 2'd1,
    MUL_INTEG  = 2'd2,
    MUL_DERIV  = 2'd3
  } mul_sel_e;

  typedef struct packed {
    logic [DataW-1:0]  prop_gain;
    logic [DataW-1:0]  integ_gain;
    logic [DataW-1:0]  deriv_gain;
    logic [DataW-1:0]  drive_floor;
    logic [DataW-1:0]  drive_ceiling;
    logic [BoundW-1:0] windup_bound;
    logic [DataW-1:0]  sample_period;
    logic [EnW-1:0]    term_enables;
  } cfg_t;

  typedef struct packed {
    logic     load_err;
    logic     clr_state;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     acc_clr;
    logic     acc_add;
    logic     integ_upd;
    logic     div_load;
    logic     div_step;
    logic     div_fix;
    logic     drive_load;
    logic     drive_zero;
  } ctrl_cmd_t;

  typedef struct packed {
    logic first_update;
    logic dt_zero;
  } dp_status_t;

  typedef enum logic [11:0] {
    S_IDLE    = 12'b0000_0000_0001,
    S_MUL_P   = 12'b0000_0000_0010,
    S_MUL_DT  = 12'b0000_0000_0100,
    S_INTEG   = 12'b0000_0000_1000,
    S_MUL_I   = 12'b0000_0001_0000,
    S_ACC_I   = 12'b0000_0010_0000,
    S_DIV     = 12'b0000_0100_0000,
    S_DIV_FIX = 12'b0000_1000_0000,
    S_MUL_D   = 12'b0001_0000_0000,
    S_ACC_D   = 12'b0010_0000_0000,
    S_DRIVE   = 12'b0100_0000_0000,
    S_SPARE   = 12'b1000_0000_0000
  } state_e;

endpackage

// ===== rtl/core/pidc_cfg.sv =====
// Configuration register file of the PID controller.
// Depends on pidc_pkg for the register indexes and the cfg_t bundle.
module pidc_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [pidc_pkg::IdxW-1:0]   cfg_idx_i,
  input  logic [pidc_pkg::DataW-1:0]  cfg_wdata_i,
  output pidc_pkg::cfg_t              cfg_o,
  output logic                        integ_clr_o
);

  pidc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    integ_clr_o = 1'b0;
    if (cfg_we_i) begin
      unique case (pidc_pkg::reg_idx_e'(cfg_idx_i))
        pidc_pkg::REG_PROP_GAIN:     cfg_d.prop_gain     = cfg_wdata_i;
        pidc_pkg::REG_INTEG_GAIN:    cfg_d.integ_gain    = cfg_wdata_i;
        pidc_pkg::REG_DERIV_GAIN:    cfg_d.deriv_gain    = cfg_wdata_i;
        pidc_pkg::REG_DRIVE_FLOOR:   cfg_d.drive_floor   = cfg_wdata_i;
        pidc_pkg::REG_DRIVE_CEILING: cfg_d.drive_ceiling = cfg_wdata_i;
        pidc_pkg::REG_WINDUP_BOUND:
          cfg_d.windup_bound = cfg_wdata_i[pidc_pkg::BoundW-1:0];
        pidc_pkg::REG_SAMPLE_PERIOD: cfg_d.sample_period = cfg_wdata_i;
        pidc_pkg::REG_TERM_ENABLES: begin
          cfg_d.term_enables = cfg_wdata_i[pidc_pkg::EnW-1:0];
          // Switching the integral term off also empties the integrator.
          integ_clr_o = ~cfg_wdata_i[pidc_pkg::EnInteg];
        end
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain     <= '0;
      cfg_q.integ_gain    <= '0;
      cfg_q.deriv_gain    <= '0;
      cfg_q.drive_floor   <= {1'b1, {(pidc_pkg::DataW-1){1'b0}}};
      cfg_q.drive_ceiling <= {1'b0, {(pidc_pkg::DataW-1){1'b1}}};
      cfg_q.windup_bound  <= '1;
      cfg_q.sample_period <= pidc_pkg::DataW'(655);
      cfg_q.term_enables  <= '1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/pidc_dpath.sv =====
// Datapath of the PID controller: error, shared multiplier, accumulator,
// integrator, radix-2 divider and output clamp. Depends on pidc_pkg.
module pidc_dpath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pidc_pkg::cfg_t              cfg_i,
  input  logic                        integ_clr_i,
  input  pidc_pkg::ctrl_cmd_t         cmd_i,
  input  logic [pidc_pkg::DataW-1:0]  setpoint_i,
  input  logic [pidc_pkg::DataW-1:0]  measurement_i,
  output pidc_pkg::dp_status_t        status_o,
  output logic [pidc_pkg::DataW-1:0]  drive_o
);

  localparam int DataW = pidc_pkg::DataW;
  localparam int OpW   = pidc_pkg::OpW;
  localparam int ProdW = pidc_pkg::ProdW;
  localparam int AccW  = pidc_pkg::AccW;
  localparam int DrvW  = pidc_pkg::DrvW;
  localparam int IntW  = pidc_pkg::IntW;
  localparam int DivW  = pidc_pkg::DivW;
  localparam int FracW = pidc_pkg::FracW;

  // Controller state, cleared by reset.
  logic [DataW-1:0] integ_q, integ_d;
  logic [DataW-1:0] prev_q, prev_d;
  logic             first_q, first_d;

  // Working registers.
  logic [DataW-1:0] err_q;
  logic [ProdW-1:0] prod_q;
  logic [AccW-1:0]  acc_q;
  logic [DataW-1:0] rem_q;
  logic [DivW-1:0]  divq_q;
  logic             neg_q;
  logic [DataW-1:0] dval_q;
  logic [DataW-1:0] drive_q;

  // Error, saturated to 32 bits.
  logic signed [DataW:0] diff_in;
  logic [DataW-1:0]      err_sat;
  assign diff_in = $signed({setpoint_i[DataW-1], setpoint_i})
                 - $signed({measurement_i[DataW-1], measurement_i});
  always_comb begin
    if (diff_in[DataW] != diff_in[DataW-1]) begin
      err_sat = diff_in[DataW] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    end else begin
      err_sat = diff_in[DataW-1:0];
    end
  end

  // Shared signed multiplier, operands widened by one bit.
  logic signed [OpW-1:0]   op_a, op_b;
  logic signed [2*OpW-1:0] prod_full;
  always_comb begin
    unique case (cmd_i.mul_sel)
      pidc_pkg::MUL_PROP: begin
        op_a = $signed({cfg_i.prop_gain[DataW-1], cfg_i.prop_gain});
        op_b = $signed({err_q[DataW-1], err_q});
      end
      pidc_pkg::MUL_PERIOD: begin
        op_a = $signed({err_q[DataW-1], err_q});
        op_b = $signed({1'b0, cfg_i.sample_period});
      end
      pidc_pkg::MUL_INTEG: begin
        op_a = $signed({cfg_i.integ_gain[DataW-1], cfg_i.integ_gain});
        op_b = $signed({integ_q[DataW-1], integ_q});
      end
      pidc_pkg::MUL_DERIV: begin
        op_a = $signed({cfg_i.deriv_gain[DataW-1], cfg_i.deriv_gain});
        op_b = $signed({dval_q[DataW-1], dval_q});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end
  assign prod_full = op_a * op_b;

  // Integrator step: add floor(err*dt / 2^16) and clamp to the bound.
  logic signed [IntW-1:0] integ_sum, bound_pos, bound_neg;
  logic [DataW-1:0]       integ_next;
  assign integ_sum = $signed({{(IntW-DataW){integ_q[DataW-1]}}, integ_q})
                   + $signed({{(IntW-(ProdW-FracW)){prod_q[ProdW-1]}},
                              prod_q[ProdW-1:FracW]});
  assign bound_pos = $signed({{(IntW-pidc_pkg::BoundW){1'b0}}, cfg_i.windup_bound});
  assign bound_neg = -bound_pos;
  always_comb begin
    priority if (integ_sum > bound_pos) begin
      integ_next = bound_pos[DataW-1:0];
    end else if (integ_sum < bound_neg) begin
      integ_next = bound_neg[DataW-1:0];
    end else begin
      integ_next = integ_sum[DataW-1:0];
    end
  end

  // Divider setup: magnitude of (err - previous error), scaled by 2^16.
  logic signed [DataW:0] dlt;
  logic [DataW:0]        dlt_mag;
  assign dlt     = $signed({err_q[DataW-1], err_q}) - $signed({prev_q[DataW-1], prev_q});
  assign dlt_mag = dlt[DataW] ? (~dlt + 1'b1) : dlt;

  // One restoring division step per cycle.
  logic [DataW:0] rem_sh, rem_sub;
  logic           rem_ge;
  assign rem_sh  = {rem_q, divq_q[DivW-1]};
  assign rem_ge  = rem_sh >= {1'b0, cfg_i.sample_period};
  assign rem_sub = rem_sh - {1'b0, cfg_i.sample_period};

  // Quotient sign and saturation.
  localparam logic [DivW-1:0] QMaxPos = DivW'({1'b0, {(DataW-1){1'b1}}});
  localparam logic [DivW-1:0] QMaxNeg = DivW'({1'b1, {(DataW-1){1'b0}}});
  logic [DataW-1:0] dval_next;
  logic [DivW-1:0]  divq_neg;
  assign divq_neg = ~divq_q + 1'b1;
  always_comb begin
    if (!neg_q) begin
      dval_next = (divq_q > QMaxPos) ? QMaxPos[DataW-1:0] : divq_q[DataW-1:0];
    end else begin
      dval_next = (divq_q > QMaxNeg) ? QMaxNeg[DataW-1:0] : divq_neg[DataW-1:0];
    end
  end

  // Output truncation and clamp; the ceiling test wins.
  logic signed [DrvW-1:0] drv, ceil_x, floor_x;
  logic [DataW-1:0]       drv_clamped;
  assign drv     = $signed(acc_q[AccW-1:FracW]);
  assign ceil_x  = $signed({{(DrvW-DataW){cfg_i.drive_ceiling[DataW-1]}}, cfg_i.drive_ceiling});
  assign floor_x = $signed({{(DrvW-DataW){cfg_i.drive_floor[DataW-1]}}, cfg_i.drive_floor});
  always_comb begin
    priority if (drv > ceil_x) begin
      drv_clamped = cfg_i.drive_ceiling;
    end else if (drv < floor_x) begin
      drv_clamped = cfg_i.drive_floor;
    end else begin
      drv_clamped = drv[DataW-1:0];
    end
  end

  always_comb begin
    integ_d = integ_q;
    prev_d  = prev_q;
    first_d = first_q;
    if (cmd_i.clr_state) begin
      integ_d = '0;
      prev_d  = '0;
      first_d = 1'b1;
    end else begin
      if (integ_clr_i) begin
        integ_d = '0;
      end else if (cmd_i.integ_upd) begin
        integ_d = integ_next;
      end
      if (cmd_i.drive_load && !cmd_i.drive_zero) begin
        prev_d  = err_q;
        first_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      prev_q  <= '0;
      first_q <= 1'b1;
    end else begin
      integ_q <= integ_d;
      prev_q  <= prev_d;
      first_q <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_err) begin
      err_q <= err_sat;
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_full[ProdW-1:0];
    end
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + {{(AccW-ProdW){prod_q[ProdW-1]}}, prod_q};
    end
    if (cmd_i.div_load) begin
      neg_q  <= dlt[DataW];
      rem_q  <= '0;
      divq_q <= {dlt_mag[DataW-1:0], {FracW{1'b0}}};
    end else if (cmd_i.div_step) begin
      rem_q  <= rem_ge ? rem_sub[DataW-1:0] : rem_sh[DataW-1:0];
      divq_q <= {divq_q[DivW-2:0], rem_ge};
    end
    if (cmd_i.div_fix) begin
      dval_q <= dval_next;
    end
    if (cmd_i.drive_load) begin
      drive_q <= cmd_i.drive_zero ? '0 : drv_clamped;
    end
  end

  assign status_o.first_update = first_q;
  assign status_o.dt_zero      = (cfg_i.sample_period == '0);
  assign drive_o               = drive_q;

endmodule

// ===== rtl/core/pidc_ctrl.sv =====
// Sequencer of the PID controller: input and output handshakes and the
// command schedule for the datapath. Depends on pidc_pkg.
module pidc_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        command_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  input  logic [pidc_pkg::EnW-1:0]    term_en_i,
  input  pidc_pkg::dp_status_t        status_i,
  output pidc_pkg::ctrl_cmd_t         cmd_o
);

  localparam int CntW = pidc_pkg::CntW;
  localparam logic [CntW-1:0] CntLast = CntW'(pidc_pkg::DivW - 1);

  pidc_pkg::state_e state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             rst_cmd_q, rst_cmd_d;
  logic             out_valid_q, out_valid_d;
  logic             in_xfer, slot_free, integ_on, deriv_on;

  assign in_ready_o = (state_q == pidc_pkg::S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign integ_on   = term_en_i[pidc_pkg::EnInteg];
  assign deriv_on   = term_en_i[pidc_pkg::EnDeriv] && !status_i.first_update
                   && !status_i.dt_zero;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    rst_cmd_d = rst_cmd_q;
    cmd_o     = '0;
    cmd_o.mul_sel = pidc_pkg::MUL_PROP;
    unique case (state_q)
      pidc_pkg::S_IDLE: begin
        if (in_xfer) begin
          rst_cmd_d = command_i;
          if (command_i) begin
            cmd_o.clr_state = 1'b1;
            state_d = pidc_pkg::S_DRIVE;
          end else begin
            cmd_o.load_err = 1'b1;
            cmd_o.acc_clr  = 1'b1;
            state_d = pidc_pkg::S_MUL_P;
          end
        end
      end
      pidc_pkg::S_MUL_P: begin
        cmd_o.mul_en = 1'b1;
        state_d = pidc_pkg::S_MUL_DT;
      end
      pidc_pkg::S_MUL_DT: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = pidc_pkg::MUL_PERIOD;
        cmd_o.acc_add = 1'b1;
        state_d = pidc_pkg::S_INTEG;
      end
      pidc_pkg::S_INTEG: begin
        cmd_o.integ_upd = integ_on;
        cmd_o.div_load  = 1'b1;
        cnt_d = '0;
        if (integ_on) begin
          state_d = pidc_pkg::S_MUL_I;
        end else if (deriv_on) begin
          state_d = pidc_pkg::S_DIV;
        end else begin
          state_d = pidc_pkg::S_DRIVE;
        end
      end
      pidc_pkg::S_MUL_I: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = pidc_pkg::MUL_INTEG;
        state_d = pidc_pkg::S_ACC_I;
      end
      pidc_pkg::S_ACC_I: begin
        cmd_o.acc_add = 1'b1;
        state_d = deriv_on ? pidc_pkg::S_DIV : pidc_pkg::S_DRIVE;
      end
      pidc_pkg::S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          state_d = pidc_pkg::S_DIV_FIX;
        end
      end
      pidc_pkg::S_DIV_FIX: begin
        cmd_o.div_fix = 1'b1;
        state_d = pidc_pkg::S_MUL_D;
      end
      pidc_pkg::S_MUL_D: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = pidc_pkg::MUL_DERIV;
        state_d = pidc_pkg::S_ACC_D;
      end
      pidc_pkg::S_ACC_D: begin
        cmd_o.acc_add = 1'b1;
        state_d = pidc_pkg::S_DRIVE;
      end
      pidc_pkg::S_DRIVE: begin
        // Wait here until the output register can take the result.
        if (slot_free) begin
          cmd_o.drive_load = 1'b1;
          cmd_o.drive_zero = rst_cmd_q;
          state_d = pidc_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = pidc_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.drive_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pidc_pkg::S_IDLE;
      cnt_q       <= '0;
      rst_cmd_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rst_cmd_q   <= rst_cmd_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/pid_controller_clamped.sv =====
// Top level of the clamped positional PID controller (signed Q16.16).
// Depends on pidc_pkg, pidc_cfg, pidc_ctrl and pidc_dpath.
//
//   Channel  Handshake                 Payload
//   input    in_valid_i / in_ready_o   command_i, setpoint_i, measurement_i
//   output   out_valid_o / out_ready_i drive_o
//   config   cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// One item at a time. An update with the integral and derivative terms on
// runs 48 one-bit divider steps for the derivative besides its work on the
// shared multiplier and accumulator. The integral term alone skips the
// derivative, neither term also the integral product, and a reset command
// goes straight to the result. The output register lets a new item be taken
// while a result waits; a finished item waits in its last state until that
// register is free. Reset clears the control state and the integrator.
module pid_controller_clamped (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        command_i,
  input  logic signed [31:0]          setpoint_i,
  input  logic signed [31:0]          measurement_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [31:0]          drive_o,
  input  logic                        cfg_we_i,
  input  logic [pidc_pkg::IdxW-1:0]   cfg_idx_i,
  input  logic [pidc_pkg::DataW-1:0]  cfg_wdata_i
);

  pidc_pkg::cfg_t       cfg;
  pidc_pkg::ctrl_cmd_t  cmd;
  pidc_pkg::dp_status_t status;
  logic                 integ_clr;
  logic [pidc_pkg::DataW-1:0] drive;

  pidc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg),
    .integ_clr_o (integ_clr)
  );

  pidc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .term_en_i   (cfg.term_enables),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pidc_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .integ_clr_i   (integ_clr),
    .cmd_i         (cmd),
    .setpoint_i    (setpoint_i),
    .measurement_i (measurement_i),
    .status_o      (status),
    .drive_o       (drive)
  );

  assign drive_o = $signed(drive);

  // The block works on one item at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is in progress");

  // A result only appears after the sequencer has left its idle state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without an item in progress");

  // A nonzero drive lies within the configured limits while the floor is not above the ceiling.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (drive_o != 0)
      && ($signed(cfg.drive_floor) <= $signed(cfg.drive_ceiling))
    |-> (drive_o >= $signed(cfg.drive_floor))
      && (drive_o <= $signed(cfg.drive_ceiling)))
    else $error("drive outside the output limits");

endmodule
